[rtl/hvn_pkg.sv]
package hvn_pkg;

  // default parameter values
  localparam int FRAC_BITS_DEF  = 16;
  localparam int INDEX_BITS_DEF = 16;

  // |diff| (33 bits) times inverse spacing (26 bits)
  localparam int PROD_W = 59;
  // normalized component width, largest lies in [2^30, 2^31)
  localparam int COMP_W = 31;
  // isqrt radicand, root and partial remainder widths
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;
  // quotient bits of the normal divider and dividend width
  localparam int Q_W    = 11;
  localparam int NUM_W  = 41;

  // register indexes
  localparam logic [2:0] REG_SPACING_X     = 3'd0;
  localparam logic [2:0] REG_SPACING_Z     = 3'd1;
  localparam logic [2:0] REG_INV_SPACING_X = 3'd2;
  localparam logic [2:0] REG_INV_SPACING_Z = 3'd3;
  localparam logic [2:0] REG_UV_STEP_X     = 3'd4;
  localparam logic [2:0] REG_UV_STEP_Z     = 3'd5;

  // register reset values
  localparam logic [22:0] SPACING_RST = 23'd6553600;
  localparam logic [25:0] INV_RST     = 26'd655;
  localparam logic [16:0] UV_RST      = 17'd65536;

  // saturation limits
  localparam logic [22:0] POS_MAX = 23'h7FFFFF;
  localparam logic [16:0] UV_MAX  = 17'd65536;

  // normal scales
  localparam logic [9:0] SCALE_XY = 10'd1023;
  localparam logic [9:0] SCALE_Z  = 10'd511;

  typedef struct packed {
    logic [22:0] spacing_x;
    logic [22:0] spacing_z;
    logic [25:0] inv_spacing_x;
    logic [25:0] inv_spacing_z;
    logic [16:0] uv_step_x;
    logic [16:0] uv_step_z;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        grid_x;
    logic [15:0]        grid_z;
    logic signed [31:0] center_height;
    logic signed [31:0] left_height;
    logic signed [31:0] right_height;
    logic signed [31:0] down_height;
    logic signed [31:0] up_height;
    logic               left_present;
    logic               right_present;
    logic               down_present;
    logic               up_present;
  } vtx_t;

  // position and texture results that ride along the normal pipeline
  typedef struct packed {
    logic [22:0]        pos_x;
    logic signed [31:0] pos_y;
    logic [22:0]        pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } side_t;

  // normalized component magnitudes and output signs
  typedef struct packed {
    logic [COMP_W-1:0] sx;
    logic [COMP_W-1:0] sy;
    logic [COMP_W-1:0] sz;
    logic              negx;
    logic              negz;
  } norm_t;

endpackage

[rtl/hvn_ifs.sv]
interface hvn_vtx_if;
  logic               valid;
  logic               ready;
  logic [15:0]        grid_x;
  logic [15:0]        grid_z;
  logic signed [31:0] center_height;
  logic signed [31:0] left_height;
  logic signed [31:0] right_height;
  logic signed [31:0] down_height;
  logic signed [31:0] up_height;
  logic               left_present;
  logic               right_present;
  logic               down_present;
  logic               up_present;
  modport source(output valid, grid_x, grid_z, center_height, left_height, right_height,
                 down_height, up_height, left_present, right_present, down_present,
                 up_present, input ready);
  modport sink(input valid, grid_x, grid_z, center_height, left_height, right_height,
               down_height, up_height, left_present, right_present, down_present,
               up_present, output ready);
endinterface

interface hvn_res_if;
  logic               valid;
  logic               ready;
  logic [22:0]        pos_x;
  logic signed [31:0] pos_y;
  logic [22:0]        pos_z;
  logic [31:0]        packed_normal;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  modport source(output valid, pos_x, pos_y, pos_z, packed_normal, tex_u, tex_v,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, packed_normal, tex_u, tex_v,
               output ready);
endinterface

interface hvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [25:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/hvn_front.sv]
module hvn_front import hvn_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int MAG_W      = PROD_W - FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  vtx_t             vtx,
  output logic             out_valid,
  output logic [MAG_W-1:0] mx,
  output logic [MAG_W-1:0] mz,
  output logic [1:0]       neg,
  output side_t            side
);

  localparam int PX_W = INDEX_BITS + 23;
  localparam int TX_W = INDEX_BITS + 17;

  logic [2:0] v;

  // stage 1 comb
  logic signed [31:0] lx, hx, lz, hz;
  logic signed [32:0] dx, dz;
  logic [INDEX_BITS-1:0] gx, gz;

  // stage 1 regs
  logic [32:0]        absx1, absz1;
  logic               negx1, negz1, widex1, widez1;
  logic [PX_W-1:0]    px1, pz1;
  logic [TX_W-1:0]    tu1, tv1;
  logic signed [31:0] py1;

  // stage 2 regs
  logic [PROD_W-1:0] prodx2, prodz2;
  logic              negx2, negz2, widex2, widez2;
  side_t             side2;

  // stage 3 comb
  logic [MAG_W-1:0] mx_next, mz_next;

  // pick neighbors and take central differences
  always_comb begin
    lx = vtx.left_present  ? vtx.left_height  : vtx.center_height;
    hx = vtx.right_present ? vtx.right_height : vtx.center_height;
    lz = vtx.down_present  ? vtx.down_height  : vtx.center_height;
    hz = vtx.up_present    ? vtx.up_height    : vtx.center_height;
    dx = {hx[31], hx} - {lx[31], lx};
    dz = {hz[31], hz} - {lz[31], lz};
    gx = vtx.grid_x[INDEX_BITS-1:0];
    gz = vtx.grid_z[INDEX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      absx1  <= dx[32] ? 33'(-dx) : 33'(dx);
      absz1  <= dz[32] ? 33'(-dz) : 33'(dz);
      negx1  <= dx[32];
      negz1  <= dz[32];
      widex1 <= vtx.left_present & vtx.right_present;
      widez1 <= vtx.down_present & vtx.up_present;
      px1    <= PX_W'(gx) * PX_W'(cfg.spacing_x);
      pz1    <= PX_W'(gz) * PX_W'(cfg.spacing_z);
      tu1    <= TX_W'(gx) * TX_W'(cfg.uv_step_x);
      tv1    <= TX_W'(gz) * TX_W'(cfg.uv_step_z);
      py1    <= vtx.center_height;
    end
  end

  // slope products, saturate position and texture
  always_ff @(posedge clk) begin
    if (en) begin
      prodx2       <= PROD_W'(absx1) * PROD_W'(cfg.inv_spacing_x);
      prodz2       <= PROD_W'(absz1) * PROD_W'(cfg.inv_spacing_z);
      negx2        <= negx1;
      negz2        <= negz1;
      widex2       <= widex1;
      widez2       <= widez1;
      side2.pos_x  <= (px1 > PX_W'(POS_MAX)) ? POS_MAX : px1[22:0];
      side2.pos_z  <= (pz1 > PX_W'(POS_MAX)) ? POS_MAX : pz1[22:0];
      side2.tex_u  <= (tu1 > TX_W'(UV_MAX)) ? UV_MAX : tu1[16:0];
      side2.tex_v  <= (tv1 > TX_W'(UV_MAX)) ? UV_MAX : tv1[16:0];
      side2.pos_y  <= py1;
    end
  end

  // scale by span, flip sign for the normal
  always_comb begin
    mx_next = widex2 ? MAG_W'(prodx2 >> (FRAC_BITS + 1)) : MAG_W'(prodx2 >> FRAC_BITS);
    mz_next = widez2 ? MAG_W'(prodz2 >> (FRAC_BITS + 1)) : MAG_W'(prodz2 >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx     <= mx_next;
      mz     <= mz_next;
      neg[0] <= !negx2 && (mx_next != '0);
      neg[1] <= !negz2 && (mz_next != '0);
      side   <= side2;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  assign out_valid = v[2];

endmodule

[rtl/hvn_norm.sv]
module hvn_norm import hvn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAG_W     = PROD_W - FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [MAG_W-1:0] mx,
  input  logic [MAG_W-1:0] mz,
  input  logic [1:0]       neg,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [RAD_W-1:0] sum,
  output norm_t            nrm,
  output side_t            side
);

  localparam int P_W = $clog2(MAG_W);
  localparam logic [MAG_W-1:0] MY = MAG_W'(1) << FRAC_BITS;
  localparam logic [P_W-1:0] TOP_BIT = P_W'(COMP_W - 1);

  logic [4:0] v;

  // stage regs
  logic [MAG_W-1:0] mx1, mz1, mmax1, mx2, mz2;
  logic [1:0]       neg1, neg2;
  side_t            sd1, sd2, sd3, sd4;
  logic [P_W-1:0]   p2;
  norm_t            n3, n4;
  logic [2*COMP_W-1:0] sqx4, sqy4, sqz4;

  // comb
  logic [MAG_W-1:0] mmax_next;
  logic [P_W-1:0]   p_next, sh;
  norm_t            n_next;

  // largest magnitude
  always_comb begin
    mmax_next = (mx > MY) ? mx : MY;
    if (mz > mmax_next) begin
      mmax_next = mz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1   <= mx;
      mz1   <= mz;
      mmax1 <= mmax_next;
      neg1  <= neg;
      sd1   <= side_in;
    end
  end

  // leading one position
  always_comb begin
    p_next = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mmax1[i]) begin
        p_next = P_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2   <= p_next;
      mx2  <= mx1;
      mz2  <= mz1;
      neg2 <= neg1;
      sd2  <= sd1;
    end
  end

  // common shift to put the largest in [2^30, 2^31)
  always_comb begin
    n_next.negx = neg2[0];
    n_next.negz = neg2[1];
    if (p2 > TOP_BIT) begin
      sh        = p2 - TOP_BIT;
      n_next.sx = COMP_W'(mx2 >> sh);
      n_next.sy = COMP_W'(MY >> sh);
      n_next.sz = COMP_W'(mz2 >> sh);
    end else begin
      sh        = TOP_BIT - p2;
      n_next.sx = COMP_W'(mx2 << sh);
      n_next.sy = COMP_W'(MY << sh);
      n_next.sz = COMP_W'(mz2 << sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3  <= n_next;
      sd3 <= sd2;
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      sqx4 <= n3.sx * n3.sx;
      sqy4 <= n3.sy * n3.sy;
      sqz4 <= n3.sz * n3.sz;
      n4   <= n3;
      sd4  <= sd3;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= RAD_W'(sqx4) + RAD_W'(sqy4) + RAD_W'(sqz4);
      nrm  <= n4;
      side <= sd4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  assign out_valid = v[4];

endmodule

[rtl/hvn_isqrt.sv]
module hvn_isqrt import hvn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  sum,
  input  norm_t             nrm_in,
  input  side_t             side_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] len,
  output norm_t             nrm,
  output side_t             side
);

  // one root bit per stage
  logic [ROOT_W-1:0] v;
  logic [REM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [RAD_W-1:0]  rad  [ROOT_W];
  norm_t             nq   [ROOT_W];
  side_t             sq   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in, acc, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    norm_t             n_in;
    side_t             s_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum;
      assign n_in    = nrm_in;
      assign s_in    = side_in;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
      assign rad_in  = rad[k-1];
      assign n_in    = nq[k-1];
      assign s_in    = sq[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      acc   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (acc >= trial) begin
          rem[k]  <= acc - trial;
          root[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem[k]  <= acc;
          root[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad[k] <= {rad_in[RAD_W-3:0], 2'b00};
        nq[k]  <= n_in;
        sq[k]  <= s_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ROOT_W-2:0], in_valid};
    end
  end

  assign out_valid = v[ROOT_W-1];
  assign len       = root[ROOT_W-1];
  assign nrm       = nq[ROOT_W-1];
  assign side      = sq[ROOT_W-1];

endmodule

[rtl/hvn_div.sv]
module hvn_div import hvn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] len_in,
  input  norm_t             nrm,
  input  side_t             side_in,
  output logic              out_valid,
  output logic [31:0]       packed_normal,
  output side_t             side
);

  localparam int CMP_W = ROOT_W + Q_W;
  localparam int NST   = Q_W + 2;

  logic [NST-1:0] v;

  // per stage, per lane (x, y, z)
  logic [NUM_W-1:0]  rem  [Q_W+1][3];
  logic [Q_W-1:0]    quo  [Q_W+1][3];
  logic [ROOT_W-1:0] len  [Q_W+1];
  logic [1:0]        neg  [Q_W+1];
  side_t             sd   [Q_W+1];

  // final clamp
  logic [Q_W-1:0] qx, qy, qz;

  // scaled dividends
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0][0] <= NUM_W'(nrm.sx) * NUM_W'(SCALE_XY);
      rem[0][1] <= NUM_W'(nrm.sy) * NUM_W'(SCALE_XY);
      rem[0][2] <= NUM_W'(nrm.sz) * NUM_W'(SCALE_Z);
      for (int l = 0; l < 3; l++) begin
        quo[0][l] <= '0;
      end
      len[0] <= len_in;
      neg[0] <= {nrm.negz, nrm.negx};
      sd[0]  <= side_in;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 1; j <= Q_W; j++) begin : g_stage
    logic [CMP_W-1:0] dsr;
    assign dsr = CMP_W'(len[j-1]) << (Q_W - j);

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (CMP_W'(rem[j-1][l]) >= dsr) begin
            rem[j][l] <= rem[j-1][l] - dsr[NUM_W-1:0];
            quo[j][l] <= {quo[j-1][l][Q_W-2:0], 1'b1};
          end else begin
            rem[j][l] <= rem[j-1][l];
            quo[j][l] <= {quo[j-1][l][Q_W-2:0], 1'b0};
          end
        end
        len[j] <= len[j-1];
        neg[j] <= neg[j-1];
        sd[j]  <= sd[j-1];
      end
    end
  end

  // clamp, sign and pack
  always_comb begin
    qx = (quo[Q_W][0] > Q_W'(SCALE_XY)) ? Q_W'(SCALE_XY) : quo[Q_W][0];
    qy = (quo[Q_W][1] > Q_W'(SCALE_XY)) ? Q_W'(SCALE_XY) : quo[Q_W][1];
    qz = (quo[Q_W][2] > Q_W'(SCALE_Z))  ? Q_W'(SCALE_Z)  : quo[Q_W][2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      packed_normal[10:0]  <= neg[Q_W][0] ? (11'd0 - qx) : qx;
      packed_normal[21:11] <= qy;
      packed_normal[31:22] <= neg[Q_W][1] ? (10'd0 - qz[9:0]) : qz[9:0];
      side                 <= sd[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], in_valid};
    end
  end

  assign out_valid = v[NST-1];

endmodule

[rtl/heightmap_vertex_normal_builder.sv]
// Vertex builder for a heightmap grid. Each vertex beat gives exactly one result beat:
// world position (grid index times spacing, saturated), texture coordinates (grid
// index times uv step, saturated at 1.0) and a unit normal from central differences,
// packed 11/11/10 two's complement. The pipeline takes one vertex every cycle while the
// output is not held. It runs through slopes, the normalizing shift and sum of squares,
// the square root (one root bit per stage) and the three dividers (one quotient bit per
// stage). The last stage is the output register; when it holds a result that is not
// taken, the whole pipeline holds and vtx_in.ready drops.
// Configuration writes are always taken and must only happen while the block is idle.
module heightmap_vertex_normal_builder import hvn_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  hvn_cfg_if.sink  cfg,
  hvn_vtx_if.sink  vtx_in,
  hvn_res_if.source vtx_out
);

  localparam int MAG_W = PROD_W - FRAC_BITS;

  cfg_t  regs;
  vtx_t  vtx;
  logic  en;

  logic             f_v;
  logic [MAG_W-1:0] f_mx, f_mz;
  logic [1:0]       f_neg;
  side_t            f_side;

  logic             n_v;
  logic [RAD_W-1:0] n_sum;
  norm_t            n_nrm;
  side_t            n_side;

  logic              s_v;
  logic [ROOT_W-1:0] s_len;
  norm_t             s_nrm;
  side_t             s_side;

  logic        d_v;
  logic [31:0] d_normal;
  side_t       d_side;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.spacing_x     <= SPACING_RST;
      regs.spacing_z     <= SPACING_RST;
      regs.inv_spacing_x <= INV_RST;
      regs.inv_spacing_z <= INV_RST;
      regs.uv_step_x     <= UV_RST;
      regs.uv_step_z     <= UV_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SPACING_X:     regs.spacing_x     <= cfg.data[22:0];
        REG_SPACING_Z:     regs.spacing_z     <= cfg.data[22:0];
        REG_INV_SPACING_X: regs.inv_spacing_x <= cfg.data;
        REG_INV_SPACING_Z: regs.inv_spacing_z <= cfg.data;
        REG_UV_STEP_X:     regs.uv_step_x     <= cfg.data[16:0];
        REG_UV_STEP_Z:     regs.uv_step_z     <= cfg.data[16:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output beat is held
  assign en           = !d_v || vtx_out.ready;
  assign vtx_in.ready = en;

  always_comb begin
    vtx.grid_x        = vtx_in.grid_x;
    vtx.grid_z        = vtx_in.grid_z;
    vtx.center_height = vtx_in.center_height;
    vtx.left_height   = vtx_in.left_height;
    vtx.right_height  = vtx_in.right_height;
    vtx.down_height   = vtx_in.down_height;
    vtx.up_height     = vtx_in.up_height;
    vtx.left_present  = vtx_in.left_present;
    vtx.right_present = vtx_in.right_present;
    vtx.down_present  = vtx_in.down_present;
    vtx.up_present    = vtx_in.up_present;
  end

  hvn_front #(
    .FRAC_BITS (FRAC_BITS),
    .INDEX_BITS(INDEX_BITS),
    .MAG_W     (MAG_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (regs),
    .in_valid (vtx_in.valid),
    .vtx      (vtx),
    .out_valid(f_v),
    .mx       (f_mx),
    .mz       (f_mz),
    .neg      (f_neg),
    .side     (f_side)
  );

  hvn_norm #(
    .FRAC_BITS(FRAC_BITS),
    .MAG_W    (MAG_W)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_v),
    .mx       (f_mx),
    .mz       (f_mz),
    .neg      (f_neg),
    .side_in  (f_side),
    .out_valid(n_v),
    .sum      (n_sum),
    .nrm      (n_nrm),
    .side     (n_side)
  );

  hvn_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (n_v),
    .sum      (n_sum),
    .nrm_in   (n_nrm),
    .side_in  (n_side),
    .out_valid(s_v),
    .len      (s_len),
    .nrm      (s_nrm),
    .side     (s_side)
  );

  hvn_div u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_v),
    .len_in       (s_len),
    .nrm          (s_nrm),
    .side_in      (s_side),
    .out_valid    (d_v),
    .packed_normal(d_normal),
    .side         (d_side)
  );

  // result beat
  assign vtx_out.valid         = d_v;
  assign vtx_out.pos_x         = d_side.pos_x;
  assign vtx_out.pos_y         = d_side.pos_y;
  assign vtx_out.pos_z         = d_side.pos_z;
  assign vtx_out.packed_normal = d_normal;
  assign vtx_out.tex_u         = d_side.tex_u;
  assign vtx_out.tex_v         = d_side.tex_v;

  // root is never below any component
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    s_v |-> (s_len >= ROOT_W'(s_nrm.sx)) && (s_len >= ROOT_W'(s_nrm.sy)) &&
            (s_len >= ROOT_W'(s_nrm.sz)))
    else $error("root below a normal component");

  // y component is never negative
  a_y_sign: assert property (@(posedge clk) disable iff (rst)
    d_v |-> !d_normal[21])
    else $error("negative normal y");

  // z magnitude stays within its scale
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    d_v |-> (d_normal[31:22] != 10'h200))
    else $error("normal z out of range");

  // a result only appears when the pipeline advanced
  a_rise_on_en: assert property (@(posedge clk) disable iff (rst)
    $rose(d_v) |-> $past(en))
    else $error("result appeared during a stall");

endmodule
